/* sv/cscan_pkg.sv */
// ----------------------------------------------------------------------------
// cscan_pkg
// Shared constants, codes and types of the C-SCAN disk arm scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cscan_pkg;

	// table geometry and field widths
	localparam int QUEUE_DEPTH    = 16;
	localparam int TRACK_BITS     = 16;
	localparam int REQUESTER_BITS = 8;
	localparam int AGE_BITS       = 16;
	localparam int IDX_BITS       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS       = $clog2(QUEUE_DEPTH + 1);

	// item kinds
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// result status codes
	localparam logic STATUS_GRANT  = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// one word of the pending table
	typedef struct packed {
		logic [TRACK_BITS-1:0]     track;
		logic [REQUESTER_BITS-1:0] requester;
		logic [AGE_BITS-1:0]       age;
	} entry_t;

	// candidate for the next grant
	typedef struct packed {
		logic [IDX_BITS-1:0]       idx;
		logic [TRACK_BITS-1:0]     track;
		logic [REQUESTER_BITS-1:0] requester;
	} cand_t;

	// control from the sequencer to the picker
	typedef struct packed {
		logic                clear;
		logic                sample;
		logic                sample_valid;
		logic [IDX_BITS-1:0] sample_idx;
	} scan_ctl_t;

endpackage

`default_nettype wire

/* sv/disk_arm_cscan_scheduler.sv */
// ----------------------------------------------------------------------------
// disk_arm_cscan_scheduler
// One-direction elevator (C-SCAN) arbiter for a disk head.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. kind selects a
//   request (requester, track) or a release of the disk.
//   Results come out registered: done is high for one cycle with status,
//   grant_requester and grant_track; the receiver must take them then.
//   A request leaves busy low: its grant or reject (if any) shows on done
//   in the next cycle, and a waiting request is written to the pending
//   table at once.
//   A release with entries waiting sweeps the table through its single read
//   port, one entry per cycle: busy is high through the sweep and its
//   finish state, and the grant appears on done in the cycle in which
//   busy falls. A release with nothing waiting leaves busy low and makes
//   the disk idle without a result.
//   Reset clears the valid bits, the head track, the arrival counter and
//   marks the disk idle; the table contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_arm_cscan_scheduler (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic                                   kind,
	input  wire logic [cscan_pkg::REQUESTER_BITS-1:0]   requester,
	input  wire logic [cscan_pkg::TRACK_BITS-1:0]       track,
	output logic                                        done,
	output logic                                        status,
	output logic [cscan_pkg::REQUESTER_BITS-1:0]        grant_requester,
	output logic [cscan_pkg::TRACK_BITS-1:0]            grant_track
);
	import cscan_pkg::*;

	state_t                    state_q;
	state_t                    state_d;
	logic                      disk_busy_q;
	logic [TRACK_BITS-1:0]     head_q;
	logic [AGE_BITS-1:0]       arr_q;
	logic [QUEUE_DEPTH-1:0]    valid_q;
	logic [CNT_BITS-1:0]       cnt_q;
	logic                      rd_s1;
	logic [IDX_BITS-1:0]       idx_s1;
	logic                      done_q;
	logic                      status_q;
	logic [REQUESTER_BITS-1:0] grant_req_q;
	logic [TRACK_BITS-1:0]     grant_track_q;

	logic                      accept;
	logic                      has_free;
	logic [IDX_BITS-1:0]       free_idx;
	logic                      rd_en;
	logic                      scan_last;
	logic                      tbl_we;
	entry_t                    wr_entry;
	entry_t                    rd_entry;
	scan_ctl_t                 ctl;
	logic                      pick_found;
	cand_t                     pick_sel;

	assign accept = start && !busy;

	// lowest free slot of the table
	always_comb begin
		free_idx = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_BITS'(i);
			end
		end
		has_free = ~&valid_q;
	end

	assign scan_last = rd_s1 && (idx_s1 == IDX_BITS'(QUEUE_DEPTH - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (kind == KIND_RELEASE) && (|valid_q)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy             = 1'b1;
		rd_en            = 1'b0;
		ctl.clear        = 1'b0;
		ctl.sample       = rd_s1;
		ctl.sample_valid = valid_q[idx_s1];
		ctl.sample_idx   = idx_s1;
		case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				ctl.clear = 1'b1;
			end
			ST_SCAN: begin
				rd_en = (cnt_q < CNT_BITS'(QUEUE_DEPTH));
			end
			ST_FINISH: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// table write on a request that has to wait
	always_comb begin
		wr_entry.track     = track;
		wr_entry.requester = requester;
		wr_entry.age       = arr_q;
		tbl_we = accept && (kind == KIND_REQUEST) && disk_busy_q && has_free;
	end

	cscan_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (free_idx),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (cnt_q[IDX_BITS-1:0]),
		.rdata (rd_entry)
	);

	cscan_picker u_picker (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.entry    (rd_entry),
		.head     (head_q),
		.arrivals (arr_q),
		.found    (pick_found),
		.sel      (pick_sel)
	);

	// sweep counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rd_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= rd_en;
			if (state_q == ST_IDLE) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= cnt_q[IDX_BITS-1:0];
		end
	end

	// disk state, head, valid bits and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_busy_q <= 1'b0;
			head_q      <= '0;
			arr_q       <= '0;
			valid_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept && (kind == KIND_REQUEST)) begin
				if (!disk_busy_q) begin
					disk_busy_q <= 1'b1;
					head_q      <= track;
					done_q      <= 1'b1;
				end else if (has_free) begin
					valid_q[free_idx] <= 1'b1;
					arr_q             <= arr_q + 1'b1;
				end else begin
					done_q <= 1'b1;
				end
			end else if (accept && (kind == KIND_RELEASE) && !(|valid_q)) begin
				disk_busy_q <= 1'b0;
			end else if ((state_q == ST_FINISH) && pick_found) begin
				valid_q[pick_sel.idx] <= 1'b0;
				head_q                <= pick_sel.track;
				disk_busy_q           <= 1'b1;
				done_q                <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_REQUEST)) begin
			status_q      <= disk_busy_q ? STATUS_REJECT : STATUS_GRANT;
			grant_req_q   <= requester;
			grant_track_q <= track;
		end else if (state_q == ST_FINISH) begin
			status_q      <= STATUS_GRANT;
			grant_req_q   <= pick_sel.requester;
			grant_track_q <= pick_sel.track;
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign grant_requester = grant_req_q;
	assign grant_track     = grant_track_q;

endmodule

`default_nettype wire

/* sv/cscan_table.sv */
// ----------------------------------------------------------------------------
// cscan_table
// Pending request table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cscan_table (
	input  wire logic                               clk,
	input  wire logic                               we,
	input  wire logic [cscan_pkg::IDX_BITS-1:0]     waddr,
	input  wire cscan_pkg::entry_t                  wdata,
	input  wire logic                               re,
	input  wire logic [cscan_pkg::IDX_BITS-1:0]     raddr,
	output cscan_pkg::entry_t                       rdata
);
	import cscan_pkg::*;

	entry_t mem_q [QUEUE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered output
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/cscan_picker.sv */
// ----------------------------------------------------------------------------
// cscan_picker
// Running selection over the table sweep: best entry at or above the head
// and best entry overall, smallest track first, oldest among equal tracks.
// ----------------------------------------------------------------------------
`default_nettype none

module cscan_picker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire cscan_pkg::scan_ctl_t               ctl,
	input  wire cscan_pkg::entry_t                  entry,
	input  wire logic [cscan_pkg::TRACK_BITS-1:0]   head,
	input  wire logic [cscan_pkg::AGE_BITS-1:0]     arrivals,
	output logic                                    found,
	output cscan_pkg::cand_t                        sel
);
	import cscan_pkg::*;

	logic                up_found_q;
	cand_t               up_q;
	logic [AGE_BITS-1:0] up_wait_q;
	logic                all_found_q;
	cand_t               all_q;
	logic [AGE_BITS-1:0] all_wait_q;

	logic [AGE_BITS-1:0] waited;
	logic                in_upper;
	logic                up_better;
	logic                all_better;
	cand_t               cand;

	// compare the sampled entry against both running bests
	always_comb begin
		waited     = arrivals - entry.age;
		in_upper   = (entry.track >= head);
		cand.idx       = ctl.sample_idx;
		cand.track     = entry.track;
		cand.requester = entry.requester;
		up_better  = !up_found_q || (entry.track < up_q.track) ||
		             ((entry.track == up_q.track) && (waited > up_wait_q));
		all_better = !all_found_q || (entry.track < all_q.track) ||
		             ((entry.track == all_q.track) && (waited > all_wait_q));
	end

	// found flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_found_q  <= 1'b0;
			all_found_q <= 1'b0;
		end else if (ctl.clear) begin
			up_found_q  <= 1'b0;
			all_found_q <= 1'b0;
		end else if (ctl.sample && ctl.sample_valid) begin
			if (in_upper && up_better) begin
				up_found_q <= 1'b1;
			end
			if (all_better) begin
				all_found_q <= 1'b1;
			end
		end
	end

	// best candidates
	always_ff @(posedge clk) begin
		if (ctl.sample && ctl.sample_valid && !ctl.clear) begin
			if (in_upper && up_better) begin
				up_q      <= cand;
				up_wait_q <= waited;
			end
			if (all_better) begin
				all_q      <= cand;
				all_wait_q <= waited;
			end
		end
	end

	// upper sweep first, wrap to the lowest track otherwise
	assign found = all_found_q;
	assign sel   = up_found_q ? up_q : all_q;

endmodule

`default_nettype wire

/* sv/cscan_checker.sv */
// ----------------------------------------------------------------------------
// cscan_checker
// Port-level checks of the C-SCAN disk arm scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cscan_checker (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic                                   busy,
	input  wire logic                                   kind,
	input  wire logic [cscan_pkg::REQUESTER_BITS-1:0]   requester,
	input  wire logic [cscan_pkg::TRACK_BITS-1:0]       track,
	input  wire logic                                   done,
	input  wire logic                                   status,
	input  wire logic [cscan_pkg::REQUESTER_BITS-1:0]   grant_requester,
	input  wire logic [cscan_pkg::TRACK_BITS-1:0]       grant_track
);
	import cscan_pkg::*;

	// a release never produces a result in the next cycle
	a_release_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_RELEASE)) |=> !done)
		else $error("result right after a release transfer");

	// a request result echoes the request
	a_request_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_REQUEST)) |=>
		(!done || ((grant_track == $past(track)) &&
		           (grant_requester == $past(requester)))))
		else $error("request result does not match the request");

	// a reject follows only a request transfer
	a_reject_source: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STATUS_REJECT)) |->
		$past(start && !busy && (kind == KIND_REQUEST)))
		else $error("reject without a request transfer");

	// the block only goes busy for a release sweep
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && (kind == KIND_RELEASE)))
		else $error("busy rose without a release transfer");

endmodule

bind disk_arm_cscan_scheduler cscan_checker u_cscan_checker (.*);

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the C-SCAN disk arm scheduler: requests and
// releases go in through the start/busy handshake, a local copy of the
// pending table predicts every grant and reject, and each done strobe is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import cscan_pkg::*;

	localparam int RANDOM_ITEMS = 1650;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;

	// one predicted result
	typedef struct packed {
		logic                      status;
		logic [REQUESTER_BITS-1:0] requester;
		logic [TRACK_BITS-1:0]     track;
	} grant_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      kind;
	logic [REQUESTER_BITS-1:0] requester;
	logic [TRACK_BITS-1:0]     track;
	logic                      done;
	logic                      status;
	logic [REQUESTER_BITS-1:0] grant_requester;
	logic [TRACK_BITS-1:0]     grant_track;

	// predicted arm state and pending table
	logic                      arm_busy;
	logic [TRACK_BITS-1:0]     arm_head;
	logic [AGE_BITS-1:0]       arrivals;
	logic                      pend_valid [QUEUE_DEPTH];
	logic [TRACK_BITS-1:0]     pend_track [QUEUE_DEPTH];
	logic [REQUESTER_BITS-1:0] pend_requester [QUEUE_DEPTH];
	logic [AGE_BITS-1:0]       pend_age [QUEUE_DEPTH];

	grant_t                    grant_q [$];
	grant_t                    seen_grant;
	grant_t                    want_grant;
	logic [TRACK_BITS-1:0]     hot_tracks [4];
	int                        mismatch_count;
	int                        cycle_count;

	disk_arm_cscan_scheduler u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.requester       (requester),
		.track           (track),
		.done            (done),
		.status          (status),
		.grant_requester (grant_requester),
		.grant_track     (grant_track)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch in %s at cycle %0d: got %0h, want %0h", what, cycle_count, got,
			want);
		mismatch_count++;
	endtask

	// arrivals since a request was queued, modulo the age width
	function automatic logic [AGE_BITS-1:0] wait_span(input int slot);
		return arrivals - pend_age[slot];
	endfunction

	// pending slot with the smallest track, oldest first on ties; -1 if none
	function automatic int next_slot(input bit upper_only);
		int best;
		best = -1;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (!pend_valid[i])
				continue;
			if (upper_only && pend_track[i] < arm_head)
				continue;
			if (best < 0 || pend_track[i] < pend_track[best] ||
				(pend_track[i] == pend_track[best] && wait_span(i) > wait_span(best)))
				best = i;
		end
		return best;
	endfunction

	// advance the arm model by one accepted transfer
	function automatic void predict_grant(input logic k, input logic [REQUESTER_BITS-1:0] r,
		input logic [TRACK_BITS-1:0] t);
		int slot;
		slot = -1;
		if (k == KIND_REQUEST) begin
			if (!arm_busy) begin
				arm_busy = 1'b1;
				arm_head = t;
				grant_q.push_back('{STATUS_GRANT, r, t});
			end else begin
				for (int i = 0; i < QUEUE_DEPTH; i++)
					if (slot < 0 && !pend_valid[i])
						slot = i;
				if (slot >= 0) begin
					pend_valid[slot]     = 1'b1;
					pend_track[slot]     = t;
					pend_requester[slot] = r;
					pend_age[slot]       = arrivals;
					arrivals             = arrivals + 1'b1;
				end else begin
					grant_q.push_back('{STATUS_REJECT, r, t});
				end
			end
		end else begin
			slot = next_slot(1'b1);
			if (slot < 0)
				slot = next_slot(1'b0);
			if (slot < 0) begin
				arm_busy = 1'b0;
			end else begin
				pend_valid[slot] = 1'b0;
				arm_head         = pend_track[slot];
				arm_busy         = 1'b1;
				grant_q.push_back('{STATUS_GRANT, pend_requester[slot], pend_track[slot]});
			end
		end
	endfunction

	// drive one transfer and hold it until the block takes it
	task automatic send_item(input logic k, input logic [REQUESTER_BITS-1:0] r,
		input logic [TRACK_BITS-1:0] t);
		@(negedge clk);
		start     <= 1'b1;
		kind      <= k;
		requester <= r;
		track     <= t;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_grant(k, r, t);
	endtask

	// drop start and put junk on the item fields; n sets how long
	task automatic idle_cycles(input int n);
		if (n > 0) begin
			@(negedge clk);
			start     <= 1'b0;
			kind      <= 1'($urandom);
			requester <= REQUESTER_BITS'($urandom);
			track     <= TRACK_BITS'($urandom);
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			seen_grant = '{status, grant_requester, grant_track};
			if (grant_q.size() == 0) begin
				report_mismatch("unexpected result", int'(seen_grant), 0);
			end else begin
				want_grant = grant_q.pop_front();
				if (seen_grant.status !== want_grant.status)
					report_mismatch("status", seen_grant.status, want_grant.status);
				if (seen_grant.requester !== want_grant.requester)
					report_mismatch("grant_requester", seen_grant.requester,
						want_grant.requester);
				if (seen_grant.track !== want_grant.track)
					report_mismatch("grant_track", seen_grant.track, want_grant.track);
			end
		end
	end

	// release while idle, grant on an idle disk, release that empties the arm, then a second grant
	task automatic test_idle_release();
		send_item(KIND_RELEASE, 8'h3c, 16'h1111);
		send_item(KIND_REQUEST, 8'h00, 16'h0000);
		send_item(KIND_RELEASE, 8'h00, 16'h0000);
		send_item(KIND_REQUEST, 8'h10, 16'h8000);
	endtask

	// fill the pending table with edge tracks and ties, then get rejected
	task automatic test_table_full();
		logic [TRACK_BITS-1:0] fill_tracks [16];
		fill_tracks = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h9000, 16'h9000,
			16'h9000, 16'h8001, 16'h0000, 16'h1234, 16'hffff, 16'h4000, 16'hc000,
			16'h0001, 16'h8000, 16'h2000};
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_item(KIND_REQUEST, (i == 2) ? 8'hff : 8'(i + 1), fill_tracks[i % 16]);
		send_item(KIND_REQUEST, 8'haa, 16'h5555);
		send_item(KIND_REQUEST, 8'h55, 16'haaaa);
	endtask

	// a few releases: equal tracks at the head, then the next one up
	task automatic test_sweep_order();
		repeat (3)
			send_item(KIND_RELEASE, REQUESTER_BITS'($urandom), TRACK_BITS'($urandom));
	endtask

	// track that is random, near the head, a hot spot, or an extreme
	function automatic logic [TRACK_BITS-1:0] random_track();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			return TRACK_BITS'($urandom_range(0, 65535));
		else if (sel < 70)
			return arm_head + TRACK_BITS'($urandom_range(0, 6)) - TRACK_BITS'(3);
		else if (sel < 92)
			return hot_tracks[$urandom_range(0, 3)];
		else
			return $urandom_range(0, 1) ? '1 : '0;
	endfunction

	// bursts of mixed traffic, biased per burst to fill or drain the table
	task automatic test_random_traffic();
		int sent;
		int burst_len;
		int req_pct;
		logic k;
		sent = 0;
		foreach (hot_tracks[i])
			hot_tracks[i] = TRACK_BITS'($urandom);
		while (sent < RANDOM_ITEMS) begin
			burst_len = $urandom_range(1, 24);
			case ($urandom_range(0, 2))
				0: req_pct = 55;
				1: req_pct = 85;
				default: req_pct = 20;
			endcase
			repeat (burst_len) begin
				k = ($urandom_range(0, 99) < req_pct) ? KIND_REQUEST : KIND_RELEASE;
				sent++;
				send_item(k, REQUESTER_BITS'($urandom), random_track());
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 12));
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		kind           = KIND_REQUEST;
		requester      = '0;
		track          = '0;
		mismatch_count = 0;
		cycle_count    = 0;
		arm_busy       = 1'b0;
		arm_head       = '0;
		arrivals       = '0;
		foreach (pend_valid[i]) begin
			pend_valid[i]     = 1'b0;
			pend_track[i]     = '0;
			pend_requester[i] = '0;
			pend_age[i]       = '0;
		end
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_release();
		test_table_full();
		test_sweep_order();
		test_random_traffic();
		idle_cycles(1);

		// let the last grants come out
		wait (grant_q.size() == 0);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
